>>> rtl/lkwp_pkg.sv
// ---------------------------------------------------------------------------
// lkwp_pkg: shared types and constants of the last-k window product unit
// Control word layout, jump conditions and the sequencer program.
// ---------------------------------------------------------------------------
package lkwp_pkg;

	localparam int HISTORY_DEPTH = 1024;
	localparam int ADDR_W        = $clog2(HISTORY_DEPTH);
	localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
	localparam int K_W           = 11;
	localparam int CMP_W         = (CNT_W > K_W) ? CNT_W : K_W;
	localparam int VAL_W         = 8;
	localparam int PROD_W        = 32;
	localparam int STEP_W        = 2;
	localparam int NUM_STEPS     = 1 << STEP_W;

	localparam logic MODE_APPEND = 1'b0;
	localparam logic MODE_QUERY  = 1'b1;

	typedef logic [STEP_W-1:0] step_idx_t;

	typedef enum logic [2:0] {
		COND_NEVER,
		COND_NO_QUERY,
		COND_SHORTCUT,
		COND_MORE,
		COND_OUT_BUSY
	} cond_t;

	// datapath controls of one step
	typedef struct packed {
		logic ready;
		logic init;
		logic mul;
		logic emit;
	} ctrl_t;

	typedef struct packed {
		ctrl_t     ctrl;
		cond_t     cond;
		step_idx_t target;
	} uword_t;

	// status seen by the sequencer
	typedef struct packed {
		logic query_accept;
		logic shortcut;
		logic more;
		logic out_busy;
	} status_t;

	localparam step_idx_t STEP_WAIT  = 2'd0;
	localparam step_idx_t STEP_CHECK = 2'd1;
	localparam step_idx_t STEP_MUL   = 2'd2;
	localparam step_idx_t STEP_OUT   = 2'd3;

	// taken jump goes to target, otherwise fall through to the next step
	localparam uword_t PROGRAM [NUM_STEPS] = '{
		'{ctrl: '{ready: 1'b1, init: 1'b0, mul: 1'b0, emit: 1'b0},
			cond: COND_NO_QUERY, target: STEP_WAIT},
		'{ctrl: '{ready: 1'b0, init: 1'b1, mul: 1'b0, emit: 1'b0},
			cond: COND_SHORTCUT, target: STEP_OUT},
		'{ctrl: '{ready: 1'b0, init: 1'b0, mul: 1'b1, emit: 1'b0},
			cond: COND_MORE, target: STEP_MUL},
		'{ctrl: '{ready: 1'b0, init: 1'b0, mul: 1'b0, emit: 1'b1},
			cond: COND_OUT_BUSY, target: STEP_OUT}
	};

endpackage

>>> rtl/last_k_window_product_unit.sv
// ---------------------------------------------------------------------------
// last_k_window_product_unit: product of the k most recent values
// Append requests fill a ring of recent values; query requests multiply the
// last k of them with saturation to 32 bits.
// ---------------------------------------------------------------------------
// An append request keeps the sequencer in its wait step, so the block is
// ready again in the next cycle. A query request occupies the block for one
// accept step, one check step, k multiply steps and one output step; a query
// that ends early (window too long, a zero in the window, or k of zero) skips
// the multiply steps. The single 32x8 multiplier and the single read port of
// the history memory together consume one stored value per cycle. The result
// sits in an output register, so the output step finishes as soon as that
// register is free. No request is taken while a query is in progress.
module last_k_window_product_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [7:0] value, [18:8] window_length, [23:19] zero
	input  logic [0:0]  s_tuser,   // [0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] product
	output logic [1:0]  m_tuser    // [0] overflow, [1] bad_window
);

	localparam int AW = lkwp_pkg::ADDR_W;
	localparam int CW = lkwp_pkg::CNT_W;
	localparam int MW = lkwp_pkg::CMP_W;
	localparam int PW = lkwp_pkg::PROD_W;
	localparam int VW = lkwp_pkg::VAL_W;
	localparam logic [AW-1:0] LAST_ADDR = AW'(lkwp_pkg::HISTORY_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(lkwp_pkg::HISTORY_DEPTH);

	lkwp_pkg::ctrl_t   ctrl;
	lkwp_pkg::status_t status;

	logic [VW-1:0] mem [lkwp_pkg::HISTORY_DEPTH];
	logic [VW-1:0] rd_data_q;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] stored_cnt_q;
	logic [CW-1:0] since_zero_q;
	logic [MW-1:0] remain_q;
	logic [PW-1:0] acc_q;
	logic          ovf_q;
	logic          bad_q;
	logic [PW-1:0] out_prod_q;
	logic          out_ovf_q;
	logic          out_bad_q;
	logic          out_valid_q;
	logic [10:0]   k_q;

	logic [VW-1:0]      in_value;
	logic [10:0]        in_k;
	logic               in_mode;
	logic               accept;
	logic               append;
	logic [MW-1:0]      k_ext;
	logic               too_long;
	logic               has_zero;
	logic [AW-1:0]      newest;
	logic [PW+VW-1:0]   mul_full;
	logic               out_free;

	assign in_value = s_tdata[7:0];
	assign in_k     = s_tdata[18:8];
	assign in_mode  = s_tuser[0];

	assign s_tready = ctrl.ready;
	assign accept   = s_tvalid && s_tready;
	assign append   = accept && (in_mode == lkwp_pkg::MODE_APPEND);

	assign k_ext    = MW'(k_q);
	assign too_long = k_ext > MW'(stored_cnt_q);
	assign has_zero = k_ext > MW'(since_zero_q);
	assign newest   = (wr_ptr_q == '0) ? LAST_ADDR : wr_ptr_q - AW'(1);
	assign out_free = !out_valid_q || m_tready;

	assign status.query_accept = accept && (in_mode == lkwp_pkg::MODE_QUERY);
	assign status.shortcut     = too_long || has_zero || (k_q == '0);
	assign status.more         = remain_q != MW'(1);
	assign status.out_busy     = !out_free;

	lkwp_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	// read the newest value in the check step, then walk backward
	assign rd_addr  = ctrl.init ? newest : rd_ptr_q;
	assign mul_full = acc_q * (PW+VW)'(rd_data_q);

	always_ff @(posedge clk) begin
		if (append) begin
			mem[wr_ptr_q] <= in_value;
		end
		rd_data_q <= mem[rd_addr];
	end

	// history bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q     <= '0;
			stored_cnt_q <= '0;
			since_zero_q <= '0;
		end else if (append) begin
			wr_ptr_q     <= (wr_ptr_q == LAST_ADDR) ? '0 : wr_ptr_q + AW'(1);
			stored_cnt_q <= (stored_cnt_q == FULL_CNT) ? FULL_CNT : stored_cnt_q + CW'(1);
			if (in_value == '0) begin
				since_zero_q <= '0;
			end else begin
				since_zero_q <= (since_zero_q == FULL_CNT) ? FULL_CNT
					: since_zero_q + CW'(1);
			end
		end
	end

	// hold the window length of the accepted query for the check step
	always_ff @(posedge clk) begin
		if (status.query_accept) begin
			k_q <= in_k;
		end
	end

	// query datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remain_q <= '0;
		end else if (ctrl.init) begin
			remain_q <= k_ext;
		end else if (ctrl.mul) begin
			remain_q <= remain_q - MW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.init) begin
			rd_ptr_q <= (newest == '0) ? LAST_ADDR : newest - AW'(1);
			acc_q    <= (too_long || has_zero) ? '0 : PW'(1);
			ovf_q    <= 1'b0;
			bad_q    <= too_long;
		end else if (ctrl.mul) begin
			rd_ptr_q <= (rd_ptr_q == '0) ? LAST_ADDR : rd_ptr_q - AW'(1);
			// saturate once the product leaves 32 bits
			if (mul_full[PW+VW-1:PW] != '0) begin
				acc_q <= '1;
				ovf_q <= 1'b1;
			end else begin
				acc_q <= mul_full[PW-1:0];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.emit && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit && out_free) begin
			out_prod_q <= acc_q;
			out_ovf_q  <= ovf_q;
			out_bad_q  <= bad_q;
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = out_prod_q;
	assign m_tuser[0] = out_ovf_q;
	assign m_tuser[1] = out_bad_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stored_cnt_q <= FULL_CNT && since_zero_q <= stored_cnt_q)
		else $error("history counts out of range");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1]) |-> (m_tdata == '0 && !m_tuser[0]))
		else $error("bad window result not zero");

	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata == '1))
		else $error("overflow result not saturated");

	a_busy_query: assert property (@(posedge clk) disable iff (!arst_n)
		status.query_accept |=> !s_tready)
		else $error("request taken right after a query");

endmodule

>>> rtl/lkwp_seq.sv
// ---------------------------------------------------------------------------
// lkwp_seq: microcode sequencer
// Step counter, program table lookup and conditional jump.
// ---------------------------------------------------------------------------
module lkwp_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  lkwp_pkg::status_t status,
	output lkwp_pkg::ctrl_t   ctrl
);

	lkwp_pkg::step_idx_t pc_q;
	lkwp_pkg::step_idx_t pc_d;
	lkwp_pkg::uword_t    uword;
	logic                taken;

	assign uword = lkwp_pkg::PROGRAM[pc_q];
	assign ctrl  = uword.ctrl;

	always_comb begin
		unique case (uword.cond)
			lkwp_pkg::COND_NEVER:    taken = 1'b0;
			lkwp_pkg::COND_NO_QUERY: taken = !status.query_accept;
			lkwp_pkg::COND_SHORTCUT: taken = status.shortcut;
			lkwp_pkg::COND_MORE:     taken = status.more;
			lkwp_pkg::COND_OUT_BUSY: taken = status.out_busy;
			default:                 taken = 1'b0;
		endcase
		// fall-through wraps from the last step back to the first
		pc_d = taken ? uword.target : pc_q + lkwp_pkg::step_idx_t'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= lkwp_pkg::STEP_WAIT;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule

>>> sim/lkwp_window_checker.sv
// ---------------------------------------------------------------------------
// lkwp_window_checker: scoreboard for the last-k window product unit
// Mirrors the ring of recent values from accepted append requests, computes
// the saturated window product for each accepted query request and compares
// it field by field with the results taken from the master side.
// ---------------------------------------------------------------------------
module lkwp_window_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,   // [7:0] value, [18:8] window_length, [23:19] zero
	input  logic [0:0]  s_tuser,   // [0] mode
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // [31:0] product
	input  logic [1:0]  m_tuser,   // [0] overflow, [1] bad_window
	output int          mismatches,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [lkwp_pkg::PROD_W-1:0] product;
		logic                        overflow;
		logic                        bad_window;
	} window_result_t;

	logic [lkwp_pkg::VAL_W-1:0]  history [lkwp_pkg::HISTORY_DEPTH];
	logic [lkwp_pkg::ADDR_W-1:0] wr_ptr;
	logic [lkwp_pkg::CNT_W-1:0]  held;
	logic [lkwp_pkg::CNT_W-1:0]  since_zero;
	window_result_t              pending_products [$];
	int                          fail_count;

	// walk back from the newest value, saturating at 32 bits
	function automatic window_result_t window_product(input logic [lkwp_pkg::K_W-1:0] k);
		window_result_t              r;
		logic [63:0]                 acc;
		logic [lkwp_pkg::ADDR_W-1:0] idx;
		r = '0;
		if (k > held) begin
			r.bad_window = 1'b1;
		end else if (k <= since_zero) begin
			acc = 64'd1;
			idx = wr_ptr;
			for (int i = 0; i < k; i++) begin
				idx = idx - 1'b1;
				acc = acc * history[idx];
				if (acc > 64'hFFFF_FFFF) begin
					acc = 64'hFFFF_FFFF;
					r.overflow = 1'b1;
				end
			end
			r.product = acc[lkwp_pkg::PROD_W-1:0];
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		window_result_t want;
		if (!arst_n) begin
			wr_ptr      <= '0;
			held        <= '0;
			since_zero  <= '0;
			pending_products.delete();
			fail_count  = 0;
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_products.size() == 0) begin
					$display("%0t: result with none expected: product %h flags %b",
						$time, m_tdata, m_tuser);
					fail_count++;
				end else begin
					want = pending_products.pop_front();
					if (m_tdata !== want.product) begin
						$display("%0t: product mismatch: expected %h, got %h",
							$time, want.product, m_tdata);
						fail_count++;
					end
					if (m_tuser[0] !== want.overflow) begin
						$display("%0t: overflow mismatch: expected %b, got %b",
							$time, want.overflow, m_tuser[0]);
						fail_count++;
					end
					if (m_tuser[1] !== want.bad_window) begin
						$display("%0t: bad_window mismatch: expected %b, got %b",
							$time, want.bad_window, m_tuser[1]);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser[0] == lkwp_pkg::MODE_QUERY) begin
					pending_products = {pending_products, window_product(s_tdata[18:8])};
				end else begin
					history[wr_ptr] <= s_tdata[7:0];
					wr_ptr          <= wr_ptr + 1'b1;
					held            <= (held < lkwp_pkg::HISTORY_DEPTH) ? held + 1'b1 : held;
					if (s_tdata[7:0] == '0)
						since_zero <= '0;
					else if (since_zero < lkwp_pkg::HISTORY_DEPTH)
						since_zero <= since_zero + 1'b1;
				end
			end
			mismatches  <= fail_count;
			outstanding <= pending_products.size();
		end
	end

endmodule

>>> sim/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: testbench for last_k_window_product_unit
// Directed requests for empty and too-long windows, zeros, overflow and the
// empty product, a long fill with no zeros, then a random mix of appends and
// queries with random idle and stall bursts on both sides.
// ---------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_REQUESTS = 250;
	localparam int QUIET_TAIL      = 60;
	localparam int FILL_REQUESTS   = 300;
	localparam int DRAIN_CYCLES    = 1100;
	localparam int CYCLE_LIMIT     = 2_000_000;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata  = '0;
	logic [0:0]  s_tuser  = lkwp_pkg::MODE_APPEND;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;

	int mismatches;
	int outstanding;
	int cycle_count = 0;
	int stall_left  = 0;
	int sent        = 0;
	int held_cnt    = 0;
	int run_cnt     = 0;
	bit quiet       = 1'b0;

	always #6 clk = ~clk;

	last_k_window_product_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	lkwp_window_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// result sink: stall bursts, with calm stretches in which m_tready stays high
	always @(posedge clk) begin
		if (quiet || (cycle_count % 1000) >= 700) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 3) == 0) begin
			m_tready   <= 1'b0;
			stall_left <= $urandom_range(0, 4);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// hold the request until taken, then maybe leave an idle burst
	task automatic offer(input logic mode, input logic [7:0] value, input logic [10:0] k);
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {5'b0, k, value};
		do @(posedge clk); while (!s_tready);
		sent++;
		if (!quiet && (sent % 80) < 60 && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	task automatic append_value(input logic [7:0] value);
		offer(lkwp_pkg::MODE_APPEND, value, 11'($urandom_range(0, 2047)));
		held_cnt = (held_cnt < lkwp_pkg::HISTORY_DEPTH) ? held_cnt + 1 : held_cnt;
		run_cnt  = (value == 0) ? 0
			: ((run_cnt < lkwp_pkg::HISTORY_DEPTH) ? run_cnt + 1 : run_cnt);
	endtask

	task automatic query_window(input logic [10:0] k);
		offer(lkwp_pkg::MODE_QUERY, 8'($urandom_range(0, 255)), k);
	endtask

	initial begin
		int r;
		int k;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty history: too long, empty product, widest k
		query_window(11'd1);
		query_window(11'd0);
		query_window(11'd2047);
		// 255^4 still fits, a fifth factor saturates
		repeat (4) append_value(8'd255);
		query_window(11'd4);
		append_value(8'd255);
		query_window(11'd5);
		query_window(11'd1);
		// zero at the head of the window
		append_value(8'd0);
		query_window(11'd1);
		query_window(11'd2);
		query_window(11'd6);
		query_window(11'd7);
		append_value(8'd1);
		append_value(8'd2);
		query_window(11'd2);
		query_window(11'd3);
		query_window(11'd0);

		// drain everything before the fill
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);

		// long run with no zeros, then query around both ends of it
		repeat (FILL_REQUESTS) append_value(($urandom_range(0, 49) == 0) ? 8'd2 : 8'd1);
		query_window(11'(run_cnt));
		query_window(11'(held_cnt));
		query_window(11'(held_cnt + 1));
		query_window(11'd2047);
		append_value(8'd0);
		query_window(11'(held_cnt));
		query_window(11'd1);

		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			if (i == RANDOM_REQUESTS - QUIET_TAIL)
				quiet = 1'b1;
			if ($urandom_range(0, 99) < 45) begin
				r = $urandom_range(0, 99);
				if (r < 4)
					k = 0;
				else if (r < 60)
					k = $urandom_range(1, 12);
				else if (r < 72)
					k = run_cnt + $urandom_range(0, 1);
				else if (r < 82)
					k = held_cnt + $urandom_range(0, 1);
				else if (r < 90)
					k = (held_cnt > 0) ? $urandom_range(1, held_cnt) : 0;
				else
					k = $urandom_range(0, 2047);
				query_window(11'(k));
			end else begin
				r = $urandom_range(0, 99);
				if (r < 35)
					append_value(8'd1);
				else if (r < 55)
					append_value(8'd2);
				else if (r < 62)
					append_value(8'd0);
				else if (r < 70)
					append_value(8'd255);
				else if (r < 85)
					append_value(8'($urandom_range(3, 16)));
				else
					append_value(8'($urandom_range(0, 255)));
			end
		end
		s_tvalid <= 1'b0;

		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		// catch any stray result from a query still in flight
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && outstanding == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

>>> filelist.f
rtl/lkwp_pkg.sv
rtl/lkwp_seq.sv
rtl/last_k_window_product_unit.sv
sim/lkwp_window_checker.sv
sim/tb_top.sv
